>>> hw/rtl/cdes_pkg.sv
package cdes_pkg;

  // Field widths of the input beat and the result beat.
  localparam int unsigned IN_W    = 16;
  localparam int unsigned WIDE_W  = 17;
  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned MS_W    = 10;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  // Shared unit operand widths.
  localparam int unsigned ALU_A_W = 27;
  localparam int unsigned ALU_B_W = 18;
  localparam int unsigned ALU_C_W = 36;

  // Calendar constants.
  localparam logic [WIDE_W-1:0]  FIRST_YEAR  = 17'd1970;
  localparam logic [YEAR_W-1:0]  CENT_NOLEAP = 12'd2100;
  localparam logic [ALU_B_W-1:0] MS_PER_SEC  = 18'd1000;
  localparam logic [ALU_B_W-1:0] SEC_PER_MIN = 18'd60;
  localparam logic [ALU_B_W-1:0] MIN_PER_HR  = 18'd60;
  localparam logic [ALU_B_W-1:0] HR_PER_DAY  = 18'd24;
  localparam logic [ALU_B_W-1:0] MON_PER_YR  = 18'd12;
  localparam logic [ALU_B_W-1:0] DAY_PER_YR  = 18'd365;
  localparam logic [WIDE_W-1:0]  LAST_MONTH  = 17'd12;

  // Reciprocals for the carries: floor(x * RCP >> SH) equals floor(x / divisor)
  // for every 17-bit x.
  localparam logic [ALU_B_W-1:0] RCP_MS  = 18'd134218;
  localparam logic [ALU_B_W-1:0] RCP_MIN = 18'd139811;
  localparam logic [ALU_B_W-1:0] RCP_HR  = 18'd174763;
  localparam logic [ALU_B_W-1:0] RCP_MON = 18'd174763;
  localparam logic [4:0]         SH_MS   = 5'd27;
  localparam logic [4:0]         SH_MIN  = 5'd23;
  localparam logic [4:0]         SH_HR   = 5'd22;
  localparam logic [4:0]         SH_MON  = 5'd21;

  typedef enum logic [0:0] {
    ALU_SUB = 1'b0,
    ALU_MAC = 1'b1
  } alu_op_e;

  // Command to the shared unit: MAC gives a*b+c, SUB gives c-a*b.
  typedef struct packed {
    alu_op_e              op;
    logic [ALU_A_W-1:0]   a;
    logic [ALU_B_W-1:0]   b;
    logic [ALU_C_W-1:0]   c;
  } alu_cmd_t;

  typedef struct packed {
    logic [ALU_C_W-1:0] res;
    logic               borrow;
  } alu_res_t;

  typedef struct packed {
    logic [IN_W-1:0] millis_in;
    logic [IN_W-1:0] second_in;
    logic [IN_W-1:0] minute_in;
    logic [IN_W-1:0] hour_in;
    logic [IN_W-1:0] day_in;
    logic [IN_W-1:0] month_in;
    logic [IN_W-1:0] year_in;
  } date_in_t;

  typedef struct packed {
    logic               ok;
    logic [SEC_W-1:0]   norm_second;
    logic [MIN_W-1:0]   norm_minute;
    logic [HOUR_W-1:0]  norm_hour;
    logic [DAY_W-1:0]   norm_day;
    logic [MONTH_W-1:0] norm_month;
    logic [YEAR_W-1:0]  norm_year;
    logic [MS_W-1:0]    millis_out;
    logic [EPOCH_W-1:0] epoch_seconds;
  } result_t;

  // Leap rule, good for the years this block can reach with the default LAST_YEAR (up to 2099).
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != CENT_NOLEAP);
  endfunction

  // Days in a month, month numbered 1 to 12.
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] mo);
    logic [DAY_W-1:0] len;
    case (mo)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the year before the first of a month.
  function automatic logic [8:0] days_before(input logic leap,
                                             input logic [MONTH_W-1:0] mo);
    logic [8:0] base;
    logic [8:0] adj;
    case (mo)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    adj = (leap && (mo > 4'd2)) ? 9'd1 : 9'd0;
    return base + adj;
  endfunction

endpackage

>>> hw/rtl/cdes_alu.sv
module cdes_alu (
  input  cdes_pkg::alu_cmd_t cmd,
  output cdes_pkg::alu_res_t rsp
);
  import cdes_pkg::*;

  logic [ALU_A_W+ALU_B_W-1:0] prod;
  logic [ALU_C_W:0]           diff;

  // One multiply-add or one multiply-subtract per cycle, chosen by the sequencer.
  always_comb begin
    prod = cmd.a * cmd.b;
    diff = {1'b0, cmd.c} - {1'b0, prod[ALU_C_W-1:0]};
    case (cmd.op)
      ALU_MAC: begin
        rsp.res    = prod[ALU_C_W-1:0] + cmd.c;
        rsp.borrow = 1'b0;
      end
      ALU_SUB: begin
        rsp.res    = diff[ALU_C_W-1:0];
        rsp.borrow = diff[ALU_C_W];
      end
      default: begin
        rsp.res    = '0;
        rsp.borrow = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/cdes_core.sv
module cdes_core #(
  parameter int unsigned LAST_YEAR = 2099
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_valid,
  output logic               start_ready,
  input  cdes_pkg::date_in_t date_in,
  output logic               res_valid,
  input  logic               res_ready,
  output cdes_pkg::result_t  res
);
  import cdes_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_QUOT  = 12'b000000000010,
    ST_REM   = 12'b000000000100,
    ST_ADDQ  = 12'b000000001000,
    ST_CHECK = 12'b000000010000,
    ST_CLAMP = 12'b000000100000,
    ST_LOOP  = 12'b000001000000,
    ST_DAYS  = 12'b000010000000,
    ST_HRS   = 12'b000100000000,
    ST_MINS  = 12'b001000000000,
    ST_SECS  = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } state_t;

  // Which carry the divide steps are working on.
  typedef enum logic [2:0] {
    PH_MS    = 3'd0,
    PH_SEC   = 3'd1,
    PH_MIN   = 3'd2,
    PH_HOUR  = 3'd3,
    PH_MONTH = 3'd4
  } phase_t;

  localparam logic [WIDE_W-1:0] LAST_Y = WIDE_W'(LAST_YEAR);

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic              fail_r, fail_nxt;
  logic [WIDE_W-1:0] yr_r, yr_nxt;
  logic [WIDE_W-1:0] mo_r, mo_nxt;
  logic [WIDE_W-1:0] dy_r, dy_nxt;
  logic [WIDE_W-1:0] hr_r, hr_nxt;
  logic [WIDE_W-1:0] mi_r, mi_nxt;
  logic [WIDE_W-1:0] sc_r, sc_nxt;
  logic [WIDE_W-1:0] ms_r, ms_nxt;
  logic [WIDE_W-1:0] dvd_r, dvd_nxt;
  logic [WIDE_W-1:0] quo_r, quo_nxt;
  logic [WIDE_W-1:0] rem_r, rem_nxt;
  logic [ALU_C_W-1:0] acc_r, acc_nxt;

  alu_cmd_t          alu_cmd;
  alu_res_t          alu_rsp;
  logic [ALU_B_W-1:0] divisor;
  logic [ALU_B_W-1:0] recip;
  logic [4:0]        rshift;
  logic [WIDE_W-1:0] addq_tgt;
  logic              leap;
  logic [7:0]        yr_ofs;
  logic [8:0]        leap_cnt;

  cdes_alu u_alu (
    .cmd (alu_cmd),
    .rsp (alu_rsp)
  );

  // Per-phase divisor, its reciprocal and shift, and the field that receives
  // the quotient.
  always_comb begin
    case (phase_r)
      PH_MS: begin
        divisor = MS_PER_SEC;  recip = RCP_MS;  rshift = SH_MS;  addq_tgt = sc_r;
      end
      PH_SEC: begin
        divisor = SEC_PER_MIN; recip = RCP_MIN; rshift = SH_MIN; addq_tgt = mi_r;
      end
      PH_MIN: begin
        divisor = MIN_PER_HR;  recip = RCP_MIN; rshift = SH_MIN; addq_tgt = hr_r;
      end
      PH_HOUR: begin
        divisor = HR_PER_DAY;  recip = RCP_HR;  rshift = SH_HR;  addq_tgt = dy_r;
      end
      PH_MONTH: begin
        divisor = MON_PER_YR;  recip = RCP_MON; rshift = SH_MON; addq_tgt = yr_r;
      end
      default: begin
        divisor = MON_PER_YR;  recip = RCP_MON; rshift = SH_MON; addq_tgt = yr_r;
      end
    endcase
  end

  // Calendar terms of the current year; only read once the year is in range.
  always_comb begin
    leap     = is_leap(yr_r[YEAR_W-1:0]);
    yr_ofs   = 8'(yr_r[YEAR_W-1:0] - FIRST_YEAR[YEAR_W-1:0]);
    leap_cnt = ((9'(yr_ofs) + 9'd1) >> 2)
             - ((yr_r[YEAR_W-1:0] > CENT_NOLEAP) ? 9'd1 : 9'd0);
  end

  // Sequencer: every multiply and most wide adds and subtracts use the shared unit.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    fail_nxt  = fail_r;
    yr_nxt    = yr_r;
    mo_nxt    = mo_r;
    dy_nxt    = dy_r;
    hr_nxt    = hr_r;
    mi_nxt    = mi_r;
    sc_nxt    = sc_r;
    ms_nxt    = ms_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    alu_cmd   = '{op: ALU_SUB, a: '0, b: '0, c: '0};

    case (state_r)
      ST_IDLE: begin
        if (start_valid) begin
          yr_nxt    = WIDE_W'(date_in.year_in);
          mo_nxt    = WIDE_W'(date_in.month_in);
          dy_nxt    = WIDE_W'(date_in.day_in);
          hr_nxt    = WIDE_W'(date_in.hour_in);
          mi_nxt    = WIDE_W'(date_in.minute_in);
          sc_nxt    = WIDE_W'(date_in.second_in);
          ms_nxt    = WIDE_W'(date_in.millis_in);
          dvd_nxt   = WIDE_W'(date_in.millis_in);
          phase_nxt = PH_MS;
          fail_nxt  = 1'b0;
          state_nxt = ST_QUOT;
        end
      end

      // Quotient by multiplying with the reciprocal and dropping the low bits.
      ST_QUOT: begin
        alu_cmd.op = ALU_MAC;
        alu_cmd.a  = ALU_A_W'(dvd_r);
        alu_cmd.b  = recip;
        quo_nxt    = WIDE_W'(alu_rsp.res >> rshift);
        state_nxt  = ST_REM;
      end

      // Remainder is the dividend less quotient times divisor.
      ST_REM: begin
        alu_cmd.op = ALU_SUB;
        alu_cmd.a  = ALU_A_W'(quo_r);
        alu_cmd.b  = divisor;
        alu_cmd.c  = ALU_C_W'(dvd_r);
        rem_nxt    = alu_rsp.res[WIDE_W-1:0];
        state_nxt  = ST_ADDQ;
      end

      // Add the quotient into the next larger field, keep the remainder.
      ST_ADDQ: begin
        alu_cmd.op = ALU_MAC;
        alu_cmd.a  = ALU_A_W'(quo_r);
        alu_cmd.b  = ALU_B_W'(1);
        alu_cmd.c  = ALU_C_W'(addq_tgt);
        dvd_nxt    = alu_rsp.res[WIDE_W-1:0];
        case (phase_r)
          PH_MS: begin
            ms_nxt    = rem_r;
            sc_nxt    = alu_rsp.res[WIDE_W-1:0];
            phase_nxt = PH_SEC;
            state_nxt = ST_QUOT;
          end
          PH_SEC: begin
            sc_nxt    = rem_r;
            mi_nxt    = alu_rsp.res[WIDE_W-1:0];
            phase_nxt = PH_MIN;
            state_nxt = ST_QUOT;
          end
          PH_MIN: begin
            mi_nxt    = rem_r;
            hr_nxt    = alu_rsp.res[WIDE_W-1:0];
            phase_nxt = PH_HOUR;
            state_nxt = ST_QUOT;
          end
          PH_HOUR: begin
            hr_nxt    = rem_r;
            dy_nxt    = alu_rsp.res[WIDE_W-1:0];
            state_nxt = ST_CHECK;
          end
          default: begin
            mo_nxt    = rem_r + WIDE_W'(1);
            yr_nxt    = alu_rsp.res[WIDE_W-1:0];
            state_nxt = ST_CLAMP;
          end
        endcase
      end

      // Day 0 fails, month 0 becomes 1, a month above 12 carries into the year.
      ST_CHECK: begin
        if (dy_r == '0) begin
          fail_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else if (mo_r > LAST_MONTH) begin
          dvd_nxt   = mo_r - WIDE_W'(1);
          phase_nxt = PH_MONTH;
          state_nxt = ST_QUOT;
        end else begin
          if (mo_r == '0) begin
            mo_nxt = WIDE_W'(1);
          end
          state_nxt = ST_CLAMP;
        end
      end

      ST_CLAMP: begin
        if (yr_r < FIRST_YEAR) begin
          yr_nxt = FIRST_YEAR;
        end
        state_nxt = ST_LOOP;
      end

      // Walk the surplus days forward one month per cycle.
      ST_LOOP: begin
        alu_cmd.op = ALU_SUB;
        alu_cmd.a  = ALU_A_W'(1);
        alu_cmd.b  = ALU_B_W'(month_len(leap, mo_r[MONTH_W-1:0]));
        alu_cmd.c  = ALU_C_W'(dy_r);
        if (yr_r > LAST_Y) begin
          fail_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else if (alu_rsp.borrow || (alu_rsp.res == '0)) begin
          state_nxt = ST_DAYS;
        end else begin
          dy_nxt = alu_rsp.res[WIDE_W-1:0];
          if (mo_r == LAST_MONTH) begin
            mo_nxt = WIDE_W'(1);
            yr_nxt = yr_r + WIDE_W'(1);
          end else begin
            mo_nxt = mo_r + WIDE_W'(1);
          end
        end
      end

      // Day count since the epoch, then Horner steps down to seconds.
      ST_DAYS: begin
        alu_cmd.op = ALU_MAC;
        alu_cmd.a  = ALU_A_W'(yr_ofs);
        alu_cmd.b  = DAY_PER_YR;
        alu_cmd.c  = ALU_C_W'(leap_cnt)
                   + ALU_C_W'(days_before(leap, mo_r[MONTH_W-1:0]))
                   + ALU_C_W'(dy_r) - ALU_C_W'(1);
        acc_nxt    = alu_rsp.res;
        state_nxt  = ST_HRS;
      end

      ST_HRS: begin
        alu_cmd.op = ALU_MAC;
        alu_cmd.a  = acc_r[ALU_A_W-1:0];
        alu_cmd.b  = HR_PER_DAY;
        alu_cmd.c  = ALU_C_W'(hr_r);
        acc_nxt    = alu_rsp.res;
        state_nxt  = ST_MINS;
      end

      ST_MINS: begin
        alu_cmd.op = ALU_MAC;
        alu_cmd.a  = acc_r[ALU_A_W-1:0];
        alu_cmd.b  = MIN_PER_HR;
        alu_cmd.c  = ALU_C_W'(mi_r);
        acc_nxt    = alu_rsp.res;
        state_nxt  = ST_SECS;
      end

      ST_SECS: begin
        alu_cmd.op = ALU_MAC;
        alu_cmd.a  = acc_r[ALU_A_W-1:0];
        alu_cmd.b  = SEC_PER_MIN;
        alu_cmd.c  = ALU_C_W'(sc_r);
        acc_nxt    = alu_rsp.res;
        state_nxt  = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    fail_r  <= fail_nxt;
    yr_r    <= yr_nxt;
    mo_r    <= mo_nxt;
    dy_r    <= dy_nxt;
    hr_r    <= hr_nxt;
    mi_r    <= mi_nxt;
    sc_r    <= sc_nxt;
    ms_r    <= ms_nxt;
    dvd_r   <= dvd_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    acc_r   <= acc_nxt;
  end

  // Result; the date part and the count read as zero on failure.
  always_comb begin
    start_ready       = (state_r == ST_IDLE);
    res_valid         = (state_r == ST_DONE);
    res.ok            = ~fail_r;
    res.epoch_seconds = fail_r ? '0 : acc_r[EPOCH_W-1:0];
    res.millis_out    = ms_r[MS_W-1:0];
    res.norm_year     = fail_r ? '0 : yr_r[YEAR_W-1:0];
    res.norm_month    = fail_r ? '0 : mo_r[MONTH_W-1:0];
    res.norm_day      = fail_r ? '0 : dy_r[DAY_W-1:0];
    res.norm_hour     = hr_r[HOUR_W-1:0];
    res.norm_minute   = mi_r[MIN_W-1:0];
    res.norm_second   = sc_r[SEC_W-1:0];
  end

endmodule

>>> hw/rtl/calendar_date_to_epoch_seconds.sv
// Converts a broken-down Gregorian date and time into seconds since
// 1970-01-01 00:00:00 plus leftover milliseconds. Each time field carries its
// excess into the next larger one, months above twelve carry into years, a
// year below 1970 is raised to 1970 and surplus days are walked forward one
// month at a time. A day of zero after the hour carry, or a year past
// LAST_YEAR, gives ok low with the count and the date fields at zero. All
// multiplies run through one shared multiply-add/multiply-subtract unit: each
// of the four time carries takes a reciprocal multiply for the quotient, a
// multiply-subtract for the remainder and a quotient add, a month carry
// repeats those three steps, and the day walk steps one month per cycle.
// Beside these, an item passes through the accept, the day check, the year
// clamp, the Horner steps that build the count and the offer of the result.
// The block takes a new beat only when idle; a finished result moves into
// the output register, and the core holds its result while that register
// is still full.
module calendar_date_to_epoch_seconds #(
  parameter int unsigned LAST_YEAR = 2099
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // year_in[15:0], month_in[31:16], day_in[47:32], hour_in[63:48],
  // minute_in[79:64], second_in[95:80], millis_in[111:96]
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // epoch_seconds[31:0], millis_out[41:32], norm_year[53:42],
  // norm_month[57:54], norm_day[62:58], norm_hour[67:63],
  // norm_minute[73:68], norm_second[79:74]
  output logic [79:0]  out_tdata,
  // ok[0]
  output logic         out_tuser
);
  import cdes_pkg::*;

  date_in_t date_in;
  result_t  core_res;
  result_t  res_r;
  logic     core_valid;
  logic     core_ready;
  logic     out_valid_r, out_valid_nxt;

  // Unpack the input beat.
  always_comb begin
    date_in.year_in   = in_tdata[15:0];
    date_in.month_in  = in_tdata[31:16];
    date_in.day_in    = in_tdata[47:32];
    date_in.hour_in   = in_tdata[63:48];
    date_in.minute_in = in_tdata[79:64];
    date_in.second_in = in_tdata[95:80];
    date_in.millis_in = in_tdata[111:96];
  end

  cdes_core #(
    .LAST_YEAR (LAST_YEAR)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_valid (in_tvalid),
    .start_ready (in_tready),
    .date_in     (date_in),
    .res_valid   (core_valid),
    .res_ready   (core_ready),
    .res         (core_res)
  );

  // Output register: the core hands over whenever the slot is free or draining.
  assign core_ready = ~out_valid_r | out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (core_valid && core_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && core_ready) begin
      res_r <= core_res;
    end
  end

  // Pack the result beat.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.ok;
  assign out_tdata  = {res_r.norm_second, res_r.norm_minute, res_r.norm_hour,
                       res_r.norm_day, res_r.norm_month, res_r.norm_year,
                       res_r.millis_out, res_r.epoch_seconds};

endmodule
